// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
// Each macro takes a label, clock, reset, antecedent, consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_pkg
// Shared types and constants of the multi-lamp linear fader.
// ----------------------------------------------------------------------------
package mlf_pkg;

  localparam int unsigned LEVEL_W       = 24;  // current level, Q0.24
  localparam int unsigned VALUE_W       = 16;  // target, start, reported value, Q0.16
  localparam int unsigned ID_W          = 4;
  localparam int unsigned MAX_REPORT    = 16;
  localparam int unsigned DEF_NUM_LAMPS = 16;
  localparam int unsigned DEF_MIN_DELTA = 7;

  typedef enum logic [1:0] {
    OP_SET_ONE = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_TICK    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] cur;
    logic [VALUE_W-1:0] tgt;
    logic [VALUE_W-1:0] st;
  } lamp_entry_t;

endpackage

// File: rtl/core/mlf_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_update
// Modify stage of the lamp read-modify-write: set and fade arithmetic.
// Stage one registers the entry and the distance product, stage two adds
// or subtracts the step and clamps at the target.
// ----------------------------------------------------------------------------
module mlf_update import mlf_pkg::*; #(
  parameter int unsigned MIN_DELTA = DEF_MIN_DELTA
) (
  input  logic               clk,
  input  logic               calc_en,
  input  lamp_entry_t        entry,
  input  logic [VALUE_W-1:0] rate,
  input  op_t                op,
  input  logic [VALUE_W-1:0] bright,
  output lamp_entry_t        entry_new
);

  logic [VALUE_W-1:0]   mag;
  logic                 neg;
  logic [2*VALUE_W-1:0] prod;

  lamp_entry_t          ent_q;
  logic                 neg_q;
  logic                 move_q;
  logic [2*VALUE_W-1:0] prod_q;

  logic [LEVEL_W-1:0]   step;
  logic [LEVEL_W-1:0]   tgt_l;
  logic [LEVEL_W:0]     up_sum;
  logic [LEVEL_W:0]     dn_diff;
  logic [LEVEL_W-1:0]   faded;

  assign neg  = entry.tgt < entry.st;
  assign mag  = neg ? (entry.st - entry.tgt) : (entry.tgt - entry.st);
  assign prod = {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, rate};

  always_ff @(posedge clk) begin
    if (calc_en) begin
      ent_q  <= entry;
      neg_q  <= neg;
      prod_q <= prod;
      move_q <= (rate != '0) && (mag != '0) &&
                ({{(32-VALUE_W){1'b0}}, mag} >= 32'(MIN_DELTA));
    end
  end

  assign step    = prod_q[2*VALUE_W-1:8];
  assign tgt_l   = {ent_q.tgt, 8'd0};
  assign up_sum  = {1'b0, ent_q.cur} + {1'b0, step};
  assign dn_diff = {1'b0, ent_q.cur} - {1'b0, step};

  always_comb begin
    if (!move_q) begin
      faded = ent_q.cur;
    end else if (!neg_q) begin
      faded = (up_sum > {1'b0, tgt_l}) ? tgt_l : up_sum[LEVEL_W-1:0];
    end else begin
      faded = (dn_diff[LEVEL_W] || (dn_diff[LEVEL_W-1:0] < tgt_l)) ?
              tgt_l : dn_diff[LEVEL_W-1:0];
    end
  end

  always_comb begin
    entry_new = ent_q;
    case (op)
      OP_SET_ONE, OP_SET_ALL: begin
        if (rate == '0) begin
          entry_new.cur = {bright, 8'd0};
        end else begin
          entry_new.st  = ent_q.cur[LEVEL_W-1:8];
          entry_new.tgt = bright;
        end
      end
      OP_TICK: begin
        entry_new.cur = faded;
      end
      default: begin
        entry_new = ent_q;
      end
    endcase
  end

endmodule

// File: rtl/core/multi_lamp_linear_fader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lamp_linear_fader_unit
// Brightness fader for a bank of lamps, state held in one lamp memory.
// ----------------------------------------------------------------------------
// Use:
//   Command channel (cmd_valid / cmd_stall): opcode, lamp_index, brightness.
//   A word is taken when cmd_valid is high and cmd_stall is low; cmd_stall
//   is high while a command is being worked.
//   Result channel (res_valid / res_stall): lamp_id, lamp_value, last.
//   Config channel (cfg_valid / cfg_ready): fade_rate, always ready; write
//   it only while the block is idle.
// Timing:
//   Every lamp visit is a read-modify-write on the lamp memory (read,
//   multiply, add/clamp/write; a read skips the write), one lamp at a time.
//   Set-one and read visit one lamp, then return to idle; a read result
//   is loaded into the output register from the write step.
//   Set-all and tick visit every lamp in turn; a tick reports
//   the first up to sixteen lamps in order, last marking the final one.
// Stall: a result waits in the output register; a tick or read holds its write
//   stage until the register frees, so nothing is lost or repeated.
// Reset: clears the per-lamp valid bits, so every lamp reads as zero, clears
//   fade_rate and res_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_lamp_linear_fader_unit import mlf_pkg::*; #(
  parameter int unsigned NUM_LAMPS = DEF_NUM_LAMPS,
  parameter int unsigned MIN_DELTA = DEF_MIN_DELTA
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         opcode,
  input  logic [ID_W-1:0]    lamp_index,
  input  logic [VALUE_W-1:0] brightness,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic [ID_W-1:0]    lamp_id,
  output logic [VALUE_W-1:0] lamp_value,
  output logic               last,
  // config channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VALUE_W-1:0] fade_rate
);

  localparam int unsigned LW   = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam int unsigned NREP = (NUM_LAMPS > MAX_REPORT) ? MAX_REPORT : NUM_LAMPS;

  state_t             state, state_next;
  op_t                op_in;
  op_t                op;
  logic [VALUE_W-1:0] bright;
  logic [VALUE_W-1:0] rate;
  logic [LW-1:0]      cnt;
  logic [LW+3:0]      cnt_wide;
  logic [LW+3:0]      idx_wide;

  // lamp memory and its valid bits
  lamp_entry_t        mem [NUM_LAMPS];
  lamp_entry_t        rd_q;
  logic [NUM_LAMPS-1:0] vld;
  logic               vld_q;
  lamp_entry_t        entry_in;
  lamp_entry_t        entry_new;

  // sequencer controls
  logic cmd_take;
  logic load_cmd;
  logic calc_en;
  logic wr_en;
  logic emit;
  logic cnt_inc;
  logic single;
  logic in_range;
  logic need_emit;
  logic out_free;
  logic last_lamp;
  logic rep_last;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign op_in     = op_t'(opcode);

  assign idx_wide = {{LW{1'b0}}, lamp_index};
  assign cnt_wide = {4'd0, cnt};
  assign single   = (op_in == OP_SET_ONE) || (op_in == OP_READ);
  assign in_range = idx_wide < (LW+4)'(NUM_LAMPS);

  assign out_free  = !res_valid || !res_stall;
  assign last_lamp = (cnt == LW'(NUM_LAMPS - 1));
  assign rep_last  = (cnt_wide == (LW+4)'(NREP - 1));
  assign need_emit = (op == OP_READ) ||
                     ((op == OP_TICK) && (cnt_wide < (LW+4)'(NREP)));

  // hold config until the next write
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rate <= fade_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_cmd   = 1'b0;
    calc_en    = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    cnt_inc    = 1'b0;
    case (state)
      ST_IDLE: begin
        // drop set-one and read words that address no lamp
        if (cmd_take && (!single || in_range)) begin
          load_cmd   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        calc_en    = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // hold here while a result is due and the output register is full
        if (!need_emit || out_free) begin
          wr_en = (op != OP_READ);
          emit  = need_emit;
          if ((op == OP_SET_ONE) || (op == OP_READ) || last_lamp) begin
            state_next = ST_IDLE;
          end else begin
            cnt_inc    = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // latch the command word and walk the lamp counter
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      op     <= op_in;
      bright <= brightness;
      cnt    <= single ? idx_wide[LW-1:0] : '0;
    end else if (cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // lamp memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt] <= entry_new;
    end
    rd_q <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld[cnt];
      if (wr_en) begin
        vld[cnt] <= 1'b1;
      end
    end
  end

  // a lamp never written reads as all zero
  assign entry_in = vld_q ? rd_q : '0;

  mlf_update #(
    .MIN_DELTA (MIN_DELTA)
  ) u_update (
    .clk       (clk),
    .calc_en   (calc_en),
    .entry     (entry_in),
    .rate      (rate),
    .op        (op),
    .bright    (bright),
    .entry_new (entry_new)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      lamp_id    <= cnt_wide[ID_W-1:0];
      lamp_value <= entry_new.cur[LEVEL_W-1:8];
      last       <= (op == OP_READ) || rep_last;
    end
  end

endmodule

// File: rtl/core/mlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlf_checker
// Port-level checks of the fader, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlf_checker import mlf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic [1:0]  opcode,
  input logic        res_valid,
  input logic        res_stall,
  input logic [3:0]  lamp_id,
  input logic [15:0] lamp_value,
  input logic        last,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic tick_take;
  logic mid_take;

  assign tick_take = cmd_valid && !cmd_stall && (opcode == OP_TICK);
  assign mid_take  = res_valid && !res_stall && !last;

  `AM_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid, "result dropped while stalled")
  `AM_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(lamp_value) && $stable(lamp_id) && $stable(last), "stalled result changed")
  `AM_ASSERT_NEXT(a_tick_busy, clk, rst, tick_take, cmd_stall, "tick did not occupy the block")
  `AM_ASSERT_NEXT(a_report_open, clk, rst, mid_take, cmd_stall || res_valid, "report ended without last")
  `AM_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "config write refused")

endmodule

bind multi_lamp_linear_fader_unit mlf_checker u_mlf_checker (.*);
